>>> hdl/segment_square_intersection_test_assert.svh
// Assertion macros for the segment/square miss test checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef SEGMENT_SQUARE_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_SQUARE_INTERSECTION_TEST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSIT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssit assertion failed");

// Next-cycle implication, disabled during reset.
`define SSIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssit assertion failed");

`endif

>>> hdl/ssit_pkg.sv
// Shared constants for the segment/square miss test.
// No dependencies.
package ssit_pkg;
    localparam int COORD_BITS = 32;
    localparam int CW = COORD_BITS;      // coordinate width
    localparam int SW = COORD_BITS - 1;  // side length width
    localparam int UW = COORD_BITS + 2;  // doubled offset from center
    localparam int DW = COORD_BITS + 3;  // differences and sums of offsets
    localparam int PW = 2 * DW;          // products
    localparam int NW = PW + 1;          // sum of two products
    localparam int LATENCY = 5;
endpackage

>>> hdl/segment_square_intersection_test.sv
// Segment versus axis-aligned square miss test, five-stage pipeline.
// Depends on ssit_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction: square center,
//   side length and the two segment endpoints, signed Q16.16.
//   Output channel (out_valid / out_stall) returns one transaction per input:
//   outside = 1 when the segment misses the closed square.
//   Each transaction passes through five register stages before out_valid rises.
//   Throughput: one transaction per cycle unless a blocked result stalls the pipe; five in flight.
//   The product stage (eight signed 35x35 multiplies) sets the stage depth.
//   Stall: when the output register holds a result and out_stall is high,
//   every stage freezes and in_stall is raised; nothing is lost or repeated.
//   Reset clears all stage valid bits; payload registers are not reset.
//   Math: offsets are doubled (u = 2*(p - c)) so the square spans -s..s;
//   edge crossings are tested by exact cross-multiplication, |n| <= s*|d|.
//   Stages: 1 offsets, 2 outcodes and differences, 3 products,
//   4 crossing numerators, 5 compares and final decision.
module segment_square_intersection_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ssit_pkg::CW-1:0]      center_x,
    input  logic signed [ssit_pkg::CW-1:0]      center_y,
    input  logic        [ssit_pkg::SW-1:0]      side_length,
    input  logic signed [ssit_pkg::CW-1:0]      start_x,
    input  logic signed [ssit_pkg::CW-1:0]      start_y,
    input  logic signed [ssit_pkg::CW-1:0]      end_x,
    input  logic signed [ssit_pkg::CW-1:0]      end_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                outside
);
    localparam int UW = ssit_pkg::UW;
    localparam int DW = ssit_pkg::DW;
    localparam int PW = ssit_pkg::PW;
    localparam int NW = ssit_pkg::NW;
    localparam int SW = ssit_pkg::SW;

    // whole pipeline moves together unless the output is blocked
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    logic [ssit_pkg::LATENCY-2:0] v_reg;  // stages 1..4
    logic out_valid_reg, outside_reg;

    // ---------------- stage 1: doubled offsets
    logic signed [UW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [SW-1:0] s1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= (UW'(start_x) - UW'(center_x)) <<< 1;
            y1_reg <= (UW'(start_y) - UW'(center_y)) <<< 1;
            x2_reg <= (UW'(end_x) - UW'(center_x)) <<< 1;
            y2_reg <= (UW'(end_y) - UW'(center_y)) <<< 1;
            s1_reg <= side_length;
        end
    end

    // ---------------- stage 2: outcodes, differences
    logic signed [DW-1:0] sd, t2, x1d, y1d, x2d, y2d, dx, dy;
    logic [3:0] o1, o2, c1, c2;

    always_comb
    begin
        sd  = DW'($signed({1'b0, s1_reg}));
        t2  = sd <<< 1;
        x1d = DW'(x1_reg);
        y1d = DW'(y1_reg);
        x2d = DW'(x2_reg);
        y2d = DW'(y2_reg);
        dx  = x2d - x1d;
        dy  = y2d - y1d;
        o1  = {y1d < -sd, y1d > sd, x1d < -sd, x1d > sd};
        o2  = {y2d < -sd, y2d > sd, x2d < -sd, x2d > sd};
        c1  = {-x1d - y1d > t2, -x1d + y1d > t2, x1d - y1d > t2, x1d + y1d > t2};
        c2  = {-x2d - y2d > t2, -x2d + y2d > t2, x2d - y2d > t2, x2d + y2d > t2};
    end

    logic signed [DW-1:0] dx_reg, dy_reg, adx_reg, ady_reg, x1b_reg, y1b_reg;
    logic signed [DW-1:0] epx_reg, emx_reg, epy_reg, emy_reg;
    logic [SW-1:0] s2_reg;
    logic hit2_reg, rej2_reg;
    logic [3:0] span2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= dx;
            dy_reg    <= dy;
            adx_reg   <= dx[DW-1] ? -dx : dx;
            ady_reg   <= dy[DW-1] ? -dy : dy;
            x1b_reg   <= x1d;
            y1b_reg   <= y1d;
            epx_reg   <= sd - x1d;
            emx_reg   <= -sd - x1d;
            epy_reg   <= sd - y1d;
            emy_reg   <= -sd - y1d;
            s2_reg    <= s1_reg;
            hit2_reg  <= (o1 == 4'd0) || (o2 == 4'd0);
            rej2_reg  <= ((o1 & o2) != 4'd0) || ((c1 & c2) != 4'd0);
            span2_reg <= o1 | o2;
        end
    end

    // ---------------- stage 3: products
    logic signed [PW-1:0] ydx_reg, xdy_reg, pxp_reg, pxm_reg, pyp_reg, pym_reg;
    logic signed [PW-1:0] mx_reg, my_reg;
    logic signed [DW-1:0] s3;
    logic hit3_reg, rej3_reg;
    logic [3:0] span3_reg;

    assign s3 = DW'($signed({1'b0, s2_reg}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ydx_reg   <= PW'(y1b_reg) * PW'(dx_reg);
            xdy_reg   <= PW'(x1b_reg) * PW'(dy_reg);
            pxp_reg   <= PW'(epx_reg) * PW'(dy_reg);
            pxm_reg   <= PW'(emx_reg) * PW'(dy_reg);
            pyp_reg   <= PW'(epy_reg) * PW'(dx_reg);
            pym_reg   <= PW'(emy_reg) * PW'(dx_reg);
            mx_reg    <= PW'(s3) * PW'(adx_reg);
            my_reg    <= PW'(s3) * PW'(ady_reg);
            hit3_reg  <= hit2_reg;
            rej3_reg  <= rej2_reg;
            span3_reg <= span2_reg;
        end
    end

    // ---------------- stage 4: crossing numerators
    logic signed [NW-1:0] n_reg [4];
    logic signed [NW-1:0] mx4_reg, my4_reg;
    logic hit4_reg, rej4_reg;
    logic [3:0] span4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0]  <= NW'(ydx_reg) + NW'(pxp_reg);
            n_reg[1]  <= NW'(ydx_reg) + NW'(pxm_reg);
            n_reg[2]  <= NW'(xdy_reg) + NW'(pyp_reg);
            n_reg[3]  <= NW'(xdy_reg) + NW'(pym_reg);
            mx4_reg   <= NW'(mx_reg);
            my4_reg   <= NW'(my_reg);
            hit4_reg  <= hit3_reg;
            rej4_reg  <= rej3_reg;
            span4_reg <= span3_reg;
        end
    end

    // ---------------- stage 5: window compares, decision
    // sign of the direction cancels: crossing lies on the edge iff |n| <= s*|d|
    logic [3:0] cross_hit;
    logic outside_next;

    always_comb
    begin
        cross_hit[0] = (n_reg[0] <= mx4_reg) && (n_reg[0] >= -mx4_reg);
        cross_hit[1] = (n_reg[1] <= mx4_reg) && (n_reg[1] >= -mx4_reg);
        cross_hit[2] = (n_reg[2] <= my4_reg) && (n_reg[2] >= -my4_reg);
        cross_hit[3] = (n_reg[3] <= my4_reg) && (n_reg[3] >= -my4_reg);
        outside_next = !(hit4_reg || (!rej4_reg && ((cross_hit & span4_reg) != 4'd0)));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            outside_reg <= outside_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[ssit_pkg::LATENCY-3:0], in_valid};
            out_valid_reg <= v_reg[ssit_pkg::LATENCY-2];
        end
    end

    assign out_valid = out_valid_reg;
    assign outside   = outside_reg;
endmodule

>>> hdl/ssit_checker.sv
// Port-level checker for segment_square_intersection_test, with its bind.
// Depends on segment_square_intersection_test_assert.svh.
`include "segment_square_intersection_test_assert.svh"
module ssit_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic outside
);
    // input back-pressure only comes from a blocked result
    `SSIT_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
    `SSIT_ASSERT_NOW(a_stall_when_blocked, out_valid && out_stall, in_stall)
    // a blocked result stays put
    `SSIT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(outside))
    // a presented result carries a defined flag
    `SSIT_ASSERT_NOW(a_out_known, out_valid, !$isunknown(outside))
endmodule

bind segment_square_intersection_test ssit_checker u_ssit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .outside   (outside)
);
